/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every rising edge outside reset
`define OLC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never hold outside reset
`define OLC_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define OLC_ASSERT(label, clk, rstn, prop, msg)
`define OLC_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

/* src/olc_pkg.sv */
// ----------------------------------------------------------------------------
// olc_pkg
// Types and constants of the occupancy light controller.
// ----------------------------------------------------------------------------
package olc_pkg;

    // Elapsed-tick counter width
    localparam int TimerBits = 24;
    // Width of the tick threshold registers
    localparam int TicksBits = 24;
    localparam int CmpBits   = (TimerBits > TicksBits) ? TimerBits : TicksBits;
    localparam int GroupBits = 16;

    localparam int CfgIndexBits = 3;
    localparam int CfgDataBits  = 24;
    localparam int STdataBits   = 8;
    localparam int MTdataBits   = 24;

    typedef logic [TimerBits-1:0] timer_t;
    typedef logic [TicksBits-1:0] ticks_t;
    typedef logic [CmpBits-1:0]   cmp_t;
    typedef logic [GroupBits-1:0] group_t;

    localparam ticks_t RetriggerReset = ticks_t'(500);
    localparam ticks_t OccHoldReset   = ticks_t'(3000);
    localparam ticks_t VacHoldReset   = ticks_t'(30000);
    localparam ticks_t LuxTimeoutReset = ticks_t'(60000);

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_VACANT   = 2'd2
    } flow_state_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FORCE = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CODE_END      = 2'd0,
        CODE_VACANT   = 2'd1,
        CODE_OCCUPIED = 2'd2
    } action_code_t;

    typedef enum logic [CfgIndexBits-1:0] {
        REG_RETRIGGER   = 3'd0,
        REG_OCC_HOLD    = 3'd1,
        REG_VAC_HOLD    = 3'd2,
        REG_LUX_TIMEOUT = 3'd3,
        REG_LOCAL_DIM   = 3'd4,
        REG_GROUP_EN    = 3'd5,
        REG_GROUP_ADDR  = 3'd6
    } cfg_reg_t;

endpackage

/* src/occupancy_light_controller.sv */
// ----------------------------------------------------------------------------
// occupancy_light_controller
// Motion-sensor lighting sequencer: idle, occupied-lit and vacant-lit.
//
// Each input item is one 10 ms tick with motion and lux flags, or a force
// occupied / stop command, carried as the cmd code on s_tuser. An item is
// registered on entry, then processed from the input register by one state
// update and the counter compares of its state, with any announcement loaded
// into the output register. One item is accepted every cycle while the
// output register does not stall on m_tready; m_tvalid rises, from the output
// register, only for items that announce. Only the output register stalling
// on m_tready holds the input side back. Configuration writes on the cfg
// channel are always taken and must be made while no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module occupancy_light_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [olc_pkg::STdataBits-1:0]   s_tdata,   // [0] motion, [1] lux_ok
    input  logic [1:0]                       s_tuser,   // [1:0] cmd
    // Result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [olc_pkg::MTdataBits-1:0]   m_tdata,   // [0] local_dim, [1] send_group,
                                                        // [17:2] dest_group
    output logic [1:0]                       m_tuser,   // [1:0] action_code
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [olc_pkg::CfgIndexBits-1:0] cfg_index,
    input  logic [olc_pkg::CfgDataBits-1:0]  cfg_data
);

    // Configuration registers
    olc_pkg::ticks_t retrigger_reg;
    olc_pkg::ticks_t occ_hold_reg;
    olc_pkg::ticks_t vac_hold_reg;
    olc_pkg::ticks_t lux_timeout_reg;
    logic            local_dim_en_reg;
    logic            group_en_reg;
    olc_pkg::group_t group_addr_reg;

    // Input register
    logic            in_valid_reg;
    logic [1:0]      in_cmd_reg;
    logic            in_motion_reg;
    logic            in_lux_reg;

    // Flow state
    olc_pkg::flow_state_t flow_state_reg, flow_state_next;
    olc_pkg::timer_t      elapsed_reg, elapsed_next;

    // Output register
    logic                        out_valid_reg;
    olc_pkg::action_code_t       out_code_reg;
    logic                        out_local_dim_reg;
    logic                        out_send_group_reg;
    olc_pkg::group_t             out_dest_reg;

    logic                        advance;
    logic                        emit;
    olc_pkg::action_code_t       emit_code;
    olc_pkg::timer_t             elapsed_inc;
    olc_pkg::cmp_t               elapsed_cmp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retrigger_reg    <= olc_pkg::RetriggerReset;
            occ_hold_reg     <= olc_pkg::OccHoldReset;
            vac_hold_reg     <= olc_pkg::VacHoldReset;
            lux_timeout_reg  <= olc_pkg::LuxTimeoutReset;
            local_dim_en_reg <= 1'b1;
            group_en_reg     <= 1'b0;
            group_addr_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                olc_pkg::REG_RETRIGGER:   retrigger_reg    <= olc_pkg::ticks_t'(cfg_data);
                olc_pkg::REG_OCC_HOLD:    occ_hold_reg     <= olc_pkg::ticks_t'(cfg_data);
                olc_pkg::REG_VAC_HOLD:    vac_hold_reg     <= olc_pkg::ticks_t'(cfg_data);
                olc_pkg::REG_LUX_TIMEOUT: lux_timeout_reg  <= olc_pkg::ticks_t'(cfg_data);
                olc_pkg::REG_LOCAL_DIM:   local_dim_en_reg <= cfg_data[0];
                olc_pkg::REG_GROUP_EN:    group_en_reg     <= cfg_data[0];
                olc_pkg::REG_GROUP_ADDR:  group_addr_reg   <= cfg_data[olc_pkg::GroupBits-1:0];
                default: ;
            endcase
        end
    end

    // Process the held item when the output register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg    <= s_tuser;
            in_motion_reg <= s_tdata[0];
            in_lux_reg    <= s_tdata[1];
        end
    end

    // Saturating advance of the elapsed-tick counter
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign elapsed_cmp = olc_pkg::cmp_t'(elapsed_inc);

    always_comb begin
        flow_state_next = flow_state_reg;
        elapsed_next    = elapsed_reg;
        emit            = 1'b0;
        emit_code       = olc_pkg::CODE_OCCUPIED;
        unique case (in_cmd_reg)
            olc_pkg::CMD_FORCE: begin
                flow_state_next = olc_pkg::ST_OCCUPIED;
                elapsed_next    = '0;
                emit            = 1'b1;
            end
            olc_pkg::CMD_STOP: begin
                flow_state_next = olc_pkg::ST_IDLE;
                elapsed_next    = '0;
            end
            olc_pkg::CMD_TICK: begin
                unique case (flow_state_reg)
                    olc_pkg::ST_IDLE: begin
                        elapsed_next = '0;
                        if (in_lux_reg && in_motion_reg) begin
                            flow_state_next = olc_pkg::ST_OCCUPIED;
                            emit            = 1'b1;
                        end
                    end
                    olc_pkg::ST_OCCUPIED: begin
                        elapsed_next = elapsed_inc;
                        if (in_motion_reg) begin
                            if (elapsed_cmp > olc_pkg::cmp_t'(retrigger_reg)) begin
                                elapsed_next = '0;
                                emit         = 1'b1;
                            end
                        end else if (elapsed_cmp > olc_pkg::cmp_t'(occ_hold_reg)) begin
                            flow_state_next = olc_pkg::ST_VACANT;
                            elapsed_next    = '0;
                            emit            = 1'b1;
                            emit_code       = olc_pkg::CODE_VACANT;
                        end
                    end
                    olc_pkg::ST_VACANT: begin
                        elapsed_next = elapsed_inc;
                        if (in_motion_reg) begin
                            flow_state_next = olc_pkg::ST_OCCUPIED;
                            elapsed_next    = '0;
                            emit            = 1'b1;
                        end else if ((elapsed_cmp > olc_pkg::cmp_t'(lux_timeout_reg)
                                      && !in_lux_reg)
                                     || elapsed_cmp > olc_pkg::cmp_t'(vac_hold_reg)) begin
                            flow_state_next = olc_pkg::ST_IDLE;
                            elapsed_next    = '0;
                            emit            = 1'b1;
                            emit_code       = olc_pkg::CODE_END;
                        end
                    end
                    default: begin
                        // Unreachable state: fall back to idle
                        flow_state_next = olc_pkg::ST_IDLE;
                        elapsed_next    = '0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_state_reg <= olc_pkg::ST_IDLE;
            elapsed_reg    <= '0;
        end else if (advance) begin
            flow_state_reg <= flow_state_next;
            elapsed_reg    <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_code_reg       <= emit_code;
            out_local_dim_reg  <= local_dim_en_reg;
            out_send_group_reg <= group_en_reg;
            out_dest_reg       <= group_en_reg ? group_addr_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tdata  = olc_pkg::MTdataBits'({out_dest_reg, out_send_group_reg,
                                            out_local_dim_reg});

    `OLC_ASSERT(a_idle_clear, aclk, aresetn, (flow_state_reg == olc_pkg::ST_IDLE) |-> (elapsed_reg == '0), "elapsed count nonzero in idle")
    `OLC_ASSERT(a_end_to_idle, aclk, aresetn, (advance && emit && emit_code == olc_pkg::CODE_END) |=> (flow_state_reg == olc_pkg::ST_IDLE), "end announcement without return to idle")
    `OLC_ASSERT(a_emit_clears, aclk, aresetn, (advance && emit) |=> (elapsed_reg == '0), "announcement did not clear elapsed count")
    `OLC_NEVER(a_no_overrun, aclk, aresetn, advance && emit && out_valid_reg && !m_tready, "result overwrote a pending result")

endmodule
